// ----- src/iel_pkg.sv -----
// Shared widths, report codes and record types of the image extrema locator.
package iel_pkg;

    // Field widths of the pixel and report channels.
    localparam int PIX_W  = 8;
    localparam int POS_W  = 12;
    localparam int SUM_W  = 10;
    localparam int CFG_W  = 13;
    localparam int KIND_W = 3;

    // Reports per frame and the reset value of the image width register.
    localparam int NUM_REPORTS = 8;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd640;

    // Default limits of the position counters.
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Report kinds, in the order in which they leave the block.
    typedef enum logic [KIND_W-1:0] {
        KIND_MAX_SUM = 3'd0,
        KIND_MIN_SUM = 3'd1,
        KIND_MAX_R   = 3'd2,
        KIND_MAX_G   = 3'd3,
        KIND_MAX_B   = 3'd4,
        KIND_MIN_R   = 3'd5,
        KIND_MIN_G   = 3'd6,
        KIND_MIN_B   = 3'd7
    } kind_t;

    // Running extreme of the R+G+B sum, with position and color.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
    } sum_trk_t;

    // Running extreme of one color component, with position.
    typedef struct packed {
        logic [PIX_W-1:0] val;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } comp_trk_t;

    // One buffered report, without its kind.
    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] val;
    } rpt_rec_t;

endpackage

// ----- src/iel_pix_if.sv -----
// Pixel stream channel: valid, ready and one RGB pixel with its frame end mark.
interface iel_pix_if;
    import iel_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             last_pixel;

    modport source (output valid, output red, output green, output blue,
                    output last_pixel, input ready);
    modport sink (input valid, input red, input green, input blue,
                  input last_pixel, output ready);
endinterface

// ----- src/iel_rpt_if.sv -----
// Report channel: valid, ready and one extreme report.
interface iel_rpt_if;
    import iel_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] report_kind;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [PIX_W-1:0]  pix_red;
    logic [PIX_W-1:0]  pix_green;
    logic [PIX_W-1:0]  pix_blue;
    logic [PIX_W-1:0]  component_value;
    logic              last_report;

    modport source (output valid, output report_kind, output pos_x, output pos_y,
                    output pix_red, output pix_green, output pix_blue,
                    output component_value, output last_report, input ready);
    modport sink (input valid, input report_kind, input pos_x, input pos_y,
                  input pix_red, input pix_green, input pix_blue,
                  input component_value, input last_report, output ready);
endinterface

// ----- src/image_extrema_locator_core.sv -----
// Top level of the image extrema locator: position counters, trackers and report buffer.
//
// Pixels arrive in raster order, one transfer per clock while no frame end stalls, and
// the column and row of each pixel come from counters that wrap at the image width
// register (zero acts as one, values above MAX_WIDTH act as MAX_WIDTH; the row
// saturates at MAX_HEIGHT-1). An accepted pixel is held in an input register and
// updates the eight trackers from there, so the sustained rate is one pixel per clock
// outside those stalls. The pixel marked last_pixel copies the trackers, itself
// included, into an eight-entry report buffer and clears the trackers and counters;
// the buffer then sends the eight reports, one per cycle while the sink is ready, and
// the next frame's pixels keep flowing meanwhile. Only a frame end that reaches the
// trackers while the buffer still holds reports of the previous frame waits, until the
// last of those reports has been taken. Write the image width only while the block is
// idle.
module image_extrema_locator_core #(
    parameter int MAX_WIDTH  = iel_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = iel_pkg::DEF_MAX_HEIGHT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    iel_pix_if.sink                  pix,
    iel_rpt_if.source                rpt,
    input  logic                     cfg_we,
    input  logic [iel_pkg::CFG_W-1:0] cfg_wdata
);
    import iel_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CMP_W = (COL_W >= CFG_W) ? COL_W + 1 : CFG_W + 1;

    // Configuration and position counters.
    logic [CFG_W-1:0]       width_reg;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [CMP_W-1:0]       width_eff;
    logic [CMP_W-1:0]       cfg_ext;
    logic [CMP_W-1:0]       col_inc;
    logic                   col_wrap;
    logic [COL_W+POS_W-1:0] x_wide;
    logic [ROW_W+POS_W-1:0] y_wide;

    // Input register.
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_last_reg;
    logic [PIX_W-1:0] s1_red_reg, s1_green_reg, s1_blue_reg;
    logic [POS_W-1:0] s1_x_reg, s1_y_reg;

    // Handshake control.
    logic in_take;
    logic out_take;
    logic s1_adv;
    logic step;
    logic snap_free;
    logic snap_load;

    // Trackers.
    sum_trk_t   bright_reg, bright_next, bright_upd;
    sum_trk_t   dark_reg, dark_next, dark_upd;
    logic       dark_valid_reg, dark_valid_next;
    comp_trk_t  cmax_reg [3];
    comp_trk_t  cmax_next [3];
    comp_trk_t  cmax_upd [3];
    comp_trk_t  cmin_reg [3];
    comp_trk_t  cmin_next [3];
    comp_trk_t  cmin_upd [3];
    logic [2:0] cmin_valid_reg, cmin_valid_next;
    logic [PIX_W-1:0] comp [3];
    logic [SUM_W-1:0] pix_sum;

    // Report buffer.
    rpt_rec_t          snap_reg [NUM_REPORTS];
    rpt_rec_t          snap_in [NUM_REPORTS];
    logic              snap_valid_reg, snap_valid_next;
    logic [KIND_W-1:0] idx_reg, idx_next;
    logic              idx_at_end;

    // Handshakes: the input register stalls only on a frame end with a busy buffer.
    assign idx_at_end = (idx_reg == KIND_MIN_B);
    assign out_take   = snap_valid_reg && rpt.ready;
    assign snap_free  = !snap_valid_reg || (rpt.ready && idx_at_end);
    assign s1_adv     = !s1_last_reg || snap_free;
    assign step       = s1_valid_reg && s1_adv;
    assign snap_load  = step && s1_last_reg;
    assign pix.ready  = !s1_valid_reg || s1_adv;
    assign in_take    = pix.valid && pix.ready;

    // Effective width and the next column and row.
    always_comb
    begin
        cfg_ext = CMP_W'(width_reg);
        if (cfg_ext == '0)
            width_eff = CMP_W'(1);
        else if (cfg_ext > CMP_W'(MAX_WIDTH))
            width_eff = CMP_W'(MAX_WIDTH);
        else
            width_eff = cfg_ext;
        col_inc  = CMP_W'(col_reg) + CMP_W'(1);
        col_wrap = (col_inc >= width_eff);

        col_next = col_reg;
        row_next = row_reg;
        if (in_take)
        begin
            if (pix.last_pixel)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_wrap)
            begin
                col_next = '0;
                if (row_reg != ROW_W'(MAX_HEIGHT - 1))
                    row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end

        x_wide = {{POS_W{1'b0}}, col_reg};
        y_wide = {{POS_W{1'b0}}, row_reg};
    end

    assign s1_valid_next = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    // Tracker updates from the registered pixel; strict compares keep the earlier pixel.
    always_comb
    begin
        comp[0] = s1_red_reg;
        comp[1] = s1_green_reg;
        comp[2] = s1_blue_reg;
        pix_sum = SUM_W'(s1_red_reg) + SUM_W'(s1_green_reg) + SUM_W'(s1_blue_reg);

        bright_upd = bright_reg;
        if (pix_sum > bright_reg.sum)
            bright_upd = '{pix_sum, s1_x_reg, s1_y_reg, s1_red_reg, s1_green_reg, s1_blue_reg};
        dark_upd = dark_reg;
        if (!dark_valid_reg || pix_sum < dark_reg.sum)
            dark_upd = '{pix_sum, s1_x_reg, s1_y_reg, s1_red_reg, s1_green_reg, s1_blue_reg};

        for (int i = 0; i < 3; i++)
        begin
            cmax_upd[i] = cmax_reg[i];
            if (comp[i] > cmax_reg[i].val)
                cmax_upd[i] = '{comp[i], s1_x_reg, s1_y_reg};
            cmin_upd[i] = cmin_reg[i];
            if (!cmin_valid_reg[i] || comp[i] < cmin_reg[i].val)
                cmin_upd[i] = '{comp[i], s1_x_reg, s1_y_reg};
        end

        // A frame end clears every tracker after its reports are captured.
        bright_next     = bright_reg;
        dark_next       = dark_reg;
        dark_valid_next = dark_valid_reg;
        cmin_valid_next = cmin_valid_reg;
        for (int i = 0; i < 3; i++)
        begin
            cmax_next[i] = cmax_reg[i];
            cmin_next[i] = cmin_reg[i];
        end
        if (step)
        begin
            if (s1_last_reg)
            begin
                bright_next     = '0;
                dark_next       = '0;
                dark_valid_next = 1'b0;
                cmin_valid_next = '0;
                for (int i = 0; i < 3; i++)
                begin
                    cmax_next[i] = '0;
                    cmin_next[i] = '0;
                end
            end
            else
            begin
                bright_next     = bright_upd;
                dark_next       = dark_upd;
                dark_valid_next = 1'b1;
                cmin_valid_next = 3'b111;
                for (int i = 0; i < 3; i++)
                begin
                    cmax_next[i] = cmax_upd[i];
                    cmin_next[i] = cmin_upd[i];
                end
            end
        end
    end

    // Reports of the frame, built from the trackers with the last pixel included.
    always_comb
    begin
        snap_in[KIND_MAX_SUM] = '{bright_upd.x, bright_upd.y, bright_upd.r,
                                  bright_upd.g, bright_upd.b, '0};
        snap_in[KIND_MIN_SUM] = '{dark_upd.x, dark_upd.y, dark_upd.r,
                                  dark_upd.g, dark_upd.b, '0};
        for (int i = 0; i < 3; i++)
        begin
            snap_in[int'(KIND_MAX_R) + i] = '{cmax_upd[i].x, cmax_upd[i].y,
                                              '0, '0, '0, cmax_upd[i].val};
            snap_in[int'(KIND_MIN_R) + i] = '{cmin_upd[i].x, cmin_upd[i].y,
                                              '0, '0, '0, cmin_upd[i].val};
        end
    end

    // Buffer occupancy and read pointer.
    always_comb
    begin
        snap_valid_next = snap_valid_reg;
        idx_next        = idx_reg;
        if (snap_load)
        begin
            snap_valid_next = 1'b1;
            idx_next        = '0;
        end
        else if (out_take)
        begin
            if (idx_at_end)
                snap_valid_next = 1'b0;
            idx_next = idx_reg + KIND_W'(1);
        end
    end

    // Control state and trackers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= WIDTH_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
            bright_reg     <= '0;
            dark_reg       <= '0;
            dark_valid_reg <= 1'b0;
            cmin_valid_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                cmax_reg[i] <= '0;
                cmin_reg[i] <= '0;
            end
            snap_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
                width_reg <= cfg_wdata;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            if (in_take)
                s1_last_reg <= pix.last_pixel;
            bright_reg     <= bright_next;
            dark_reg       <= dark_next;
            dark_valid_reg <= dark_valid_next;
            cmin_valid_reg <= cmin_valid_next;
            for (int i = 0; i < 3; i++)
            begin
                cmax_reg[i] <= cmax_next[i];
                cmin_reg[i] <= cmin_next[i];
            end
            snap_valid_reg <= snap_valid_next;
            idx_reg        <= idx_next;
        end
    end

    // Pixel payload and report buffer contents.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_red_reg   <= pix.red;
            s1_green_reg <= pix.green;
            s1_blue_reg  <= pix.blue;
            s1_x_reg     <= x_wide[POS_W-1:0];
            s1_y_reg     <= y_wide[POS_W-1:0];
        end
        if (snap_load)
        begin
            for (int k = 0; k < NUM_REPORTS; k++)
                snap_reg[k] <= snap_in[k];
        end
    end

    // Report outputs.
    assign rpt.valid           = snap_valid_reg;
    assign rpt.report_kind     = idx_reg;
    assign rpt.pos_x           = snap_reg[idx_reg].x;
    assign rpt.pos_y           = snap_reg[idx_reg].y;
    assign rpt.pix_red         = snap_reg[idx_reg].r;
    assign rpt.pix_green       = snap_reg[idx_reg].g;
    assign rpt.pix_blue        = snap_reg[idx_reg].b;
    assign rpt.component_value = snap_reg[idx_reg].val;
    assign rpt.last_report     = idx_at_end;

    // The input register holds a pixel back only for a frame end behind a busy buffer.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |-> (s1_last_reg && snap_valid_reg))
        else $error("input register stalled without a pending frame end");

    // Counters restart after a frame end is accepted.
    a_counter_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && pix.last_pixel) |=> (col_reg == '0 && row_reg == '0))
        else $error("position counters not cleared after frame end");

    // Any ordinary pixel leaves every minimum tracker filled.
    a_min_filled: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !s1_last_reg) |=> (dark_valid_reg && (&cmin_valid_reg)))
        else $error("minimum tracker empty after a pixel");

    // The buffer empties after its eighth transfer unless a new frame loads it.
    a_buffer_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && idx_at_end && !snap_load) |=> !snap_valid_reg)
        else $error("report buffer still valid after its last transfer");

endmodule
